[sv/nalau_pkg.sv]
// Shared types and constants for the NAL access unit tracker.
// No dependencies; used by every module of the block.
package nalau_pkg;

   localparam int DEF_ENTRIES = 8;

   localparam logic [30:0] MAX_AGE_RESET = 31'(90000 * 2);

   localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
   localparam logic [4:0] TYPE_IDR      = 5'd5;
   localparam logic [4:0] TYPE_SPS      = 5'd7;
   localparam logic [4:0] TYPE_PPS      = 5'd8;

   // Bit positions inside the flags field of a slot record.
   localparam int FLAG_IDR = 0;
   localparam int FLAG_SPS = 1;
   localparam int FLAG_PPS = 2;

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   localparam logic [15:0] NAL_CNT_MAX  = 16'hFFFF;
   localparam logic [31:0] BYTE_CNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] byte_cnt;
      logic [15:0] nal_cnt;
      logic [2:0]  flags;
      logic [31:0] au_time;
   } slot_rec_type;

   // Result handed from the sequencer to the output register.
   typedef struct packed {
      logic         valid;
      slot_rec_type rec;
   } result_type;

endpackage

[sv/nalau_slot_ram.sv]
// Slot memory of the access unit table: one record per pending unit.
// One write port, one read port with registered data. Uses nalau_pkg.
module nalau_slot_ram #(
   parameter int ENTRIES = nalau_pkg::DEF_ENTRIES,
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [IW-1:0]            wr_addr,
   input  nalau_pkg::slot_rec_type  wr_data,
   input  logic [IW-1:0]            rd_addr,
   output nalau_pkg::slot_rec_type  rd_data
);

   nalau_pkg::slot_rec_type mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

[sv/nalau_out_reg.sv]
// Output register of the tracker: holds one result until the sink takes it.
// Uses nalau_pkg for the result type.
module nalau_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  nalau_pkg::result_type res,
   output logic                  res_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [79:0]           rsp_tdata,  // au_time, nal_total, au_bytes
   output logic [2:0]            rsp_tuser   // is_idr, has_sps, has_pps
);

   logic                    vld_ff;
   logic                    vld_in;
   nalau_pkg::slot_rec_type rec_ff;
   logic                    load;

   assign res_ready = !vld_ff || rsp_tready;
   assign load      = res.valid && res_ready;

   always_comb begin
      vld_in = vld_ff;
      if (load) begin
         vld_in = 1'b1;
      end else if (rsp_tready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff <= res.rec;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {rec_ff.byte_cnt, rec_ff.nal_cnt, rec_ff.au_time};
   assign rsp_tuser  = {rec_ff.flags[nalau_pkg::FLAG_PPS],
                        rec_ff.flags[nalau_pkg::FLAG_SPS],
                        rec_ff.flags[nalau_pkg::FLAG_IDR]};

endmodule

[sv/nalau_ctrl.sv]
// Sequencer of the tracker: decodes a NAL, scans the slot memory, updates
// the chosen slot and produces results. Holds the slot valid bits. Uses nalau_pkg.
module nalau_ctrl #(
   parameter int ENTRIES = nalau_pkg::DEF_ENTRIES,
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   localparam int CW = $clog2(ENTRIES + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [30:0]              max_age,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     cmd,
   input  logic [39:0]              lead,
   input  logic [15:0]              len,
   input  logic [31:0]              now,
   input  logic                     marker,
   output logic                     ram_wr_en,
   output logic [IW-1:0]            ram_wr_addr,
   output nalau_pkg::slot_rec_type  ram_wr_data,
   output logic [IW-1:0]            ram_rd_addr,
   input  nalau_pkg::slot_rec_type  ram_rd_data,
   output nalau_pkg::result_type    res,
   input  logic                     res_ready
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DECIDE = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [ENTRIES-1:0] age_mask_ff, age_mask_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [IW-1:0]      chk_idx_ff, chk_idx_in;

   logic               match_hit_ff, match_hit_in;
   logic [IW-1:0]      match_idx_ff, match_idx_in;
   nalau_pkg::slot_rec_type match_rec_ff, match_rec_in;
   logic               free_hit_ff, free_hit_in;
   logic [IW-1:0]      free_idx_ff, free_idx_in;
   logic               old_hit_ff, old_hit_in;
   logic [IW-1:0]      old_idx_ff, old_idx_in;
   nalau_pkg::slot_rec_type old_rec_ff, old_rec_in;

   // Latched item.
   logic               cmd_ff, cmd_in;
   logic [15:0]        len_ff, len_in;
   logic [31:0]        now_ff, now_in;
   logic               marker_ff, marker_in;
   logic [2:0]         tflags_ff, tflags_in;
   nalau_pkg::slot_rec_type res_rec_ff, res_rec_in;

   // Decode of the lead bytes at acceptance.
   logic [7:0]  b0, b1, b2, b3, b4;
   logic        four_byte_sc;
   logic        short_nal;
   logic [4:0]  hdr_type;
   logic [2:0]  type_flags;

   // Slot update.
   logic [IW-1:0]           slot_idx;
   nalau_pkg::slot_rec_type base_rec;
   nalau_pkg::slot_rec_type upd_rec;
   logic [32:0]             byte_sum;

   // Scan compare.
   logic        chk_slot_valid;
   logic [31:0] age_diff;

   assign b0 = lead[39:32];
   assign b1 = lead[31:24];
   assign b2 = lead[23:16];
   assign b3 = lead[15:8];
   assign b4 = lead[7:0];

   always_comb begin
      four_byte_sc = (len >= 16'd4) && (b0 == 8'h00) && (b1 == 8'h00) &&
                     (b2 == 8'h00) && (b3 == 8'h01);
      short_nal    = four_byte_sc ? (len <= 16'd4) : (len <= 16'd3);
      hdr_type     = (four_byte_sc ? b4[4:0] : b3[4:0]) & nalau_pkg::NAL_TYPE_MASK;
      type_flags   = '0;
      type_flags[nalau_pkg::FLAG_IDR] = (hdr_type == nalau_pkg::TYPE_IDR);
      type_flags[nalau_pkg::FLAG_SPS] = (hdr_type == nalau_pkg::TYPE_SPS);
      type_flags[nalau_pkg::FLAG_PPS] = (hdr_type == nalau_pkg::TYPE_PPS);
   end

   assign req_tready = (state_ff == ST_IDLE);

   // Slot choice: the matching unit, else the lowest free slot, else the oldest.
   always_comb begin
      if (match_hit_ff) begin
         slot_idx = match_idx_ff;
      end else if (free_hit_ff) begin
         slot_idx = free_idx_ff;
      end else begin
         slot_idx = old_idx_ff;
      end
      if (match_hit_ff) begin
         base_rec = match_rec_ff;
      end else begin
         base_rec          = '0;
         base_rec.au_time  = now_ff;
      end
      upd_rec        = base_rec;
      upd_rec.flags  = base_rec.flags | tflags_ff;
      upd_rec.nal_cnt = (base_rec.nal_cnt == nalau_pkg::NAL_CNT_MAX) ?
                        nalau_pkg::NAL_CNT_MAX : base_rec.nal_cnt + 16'd1;
      byte_sum       = {1'b0, base_rec.byte_cnt} + {17'd0, len_ff};
      upd_rec.byte_cnt = byte_sum[32] ? nalau_pkg::BYTE_CNT_MAX : byte_sum[31:0];
   end

   assign chk_slot_valid = valid_ff[chk_idx_ff];
   assign age_diff       = now_ff - ram_rd_data.au_time;

   assign ram_rd_addr = cnt_ff[IW-1:0];
   assign ram_wr_en   = (state_ff == ST_DECIDE) && (cmd_ff == nalau_pkg::CMD_ADD);
   assign ram_wr_addr = slot_idx;
   assign ram_wr_data = upd_rec;

   assign res.valid = (state_ff == ST_EMIT);
   assign res.rec   = res_rec_ff;

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      age_mask_in  = age_mask_ff;
      cnt_in       = cnt_ff;
      chk_vld_in   = chk_vld_ff;
      chk_idx_in   = chk_idx_ff;
      match_hit_in = match_hit_ff;
      match_idx_in = match_idx_ff;
      match_rec_in = match_rec_ff;
      free_hit_in  = free_hit_ff;
      free_idx_in  = free_idx_ff;
      old_hit_in   = old_hit_ff;
      old_idx_in   = old_idx_ff;
      old_rec_in   = old_rec_ff;
      cmd_in       = cmd_ff;
      len_in       = len_ff;
      now_in       = now_ff;
      marker_in    = marker_ff;
      tflags_in    = tflags_ff;
      res_rec_in   = res_rec_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in       = cmd;
               len_in       = len;
               now_in       = now;
               marker_in    = marker;
               tflags_in    = type_flags;
               cnt_in       = '0;
               chk_vld_in   = 1'b0;
               match_hit_in = 1'b0;
               free_hit_in  = 1'b0;
               old_hit_in   = 1'b0;
               age_mask_in  = '0;
               // A NAL no longer than its start code is dropped on the spot.
               if (cmd == nalau_pkg::CMD_FLUSH || !short_nal) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (cnt_ff < CW'(ENTRIES)) begin
               cnt_in     = cnt_ff + CW'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = cnt_ff[IW-1:0];
            end else begin
               chk_vld_in = 1'b0;
               state_in   = ST_DECIDE;
            end
            // Examine the record read in the previous cycle.
            if (chk_vld_ff) begin
               if (chk_slot_valid) begin
                  if (!match_hit_ff && ram_rd_data.au_time == now_ff) begin
                     match_hit_in = 1'b1;
                     match_idx_in = chk_idx_ff;
                     match_rec_in = ram_rd_data;
                  end
                  if (!old_hit_ff || ram_rd_data.au_time < old_rec_ff.au_time) begin
                     old_hit_in = 1'b1;
                     old_idx_in = chk_idx_ff;
                     old_rec_in = ram_rd_data;
                  end
                  age_mask_in[chk_idx_ff] = !age_diff[31] && (age_diff[30:0] > max_age);
               end else if (!free_hit_ff) begin
                  free_hit_in = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
            end
         end
         ST_DECIDE: begin
            if (cmd_ff == nalau_pkg::CMD_FLUSH) begin
               if (old_hit_ff) begin
                  valid_in[old_idx_ff] = 1'b0;
                  res_rec_in = old_rec_ff;
                  state_in   = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (marker_ff) begin
               // The completed unit leaves the table, and aged units with it.
               valid_in           = valid_ff & ~age_mask_ff;
               valid_in[slot_idx] = 1'b0;
               res_rec_in         = upd_rec;
               state_in           = ST_EMIT;
            end else begin
               valid_in[slot_idx] = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         cnt_ff     <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         cnt_ff     <= cnt_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      age_mask_ff  <= age_mask_in;
      chk_idx_ff   <= chk_idx_in;
      match_hit_ff <= match_hit_in;
      match_idx_ff <= match_idx_in;
      match_rec_ff <= match_rec_in;
      free_hit_ff  <= free_hit_in;
      free_idx_ff  <= free_idx_in;
      old_hit_ff   <= old_hit_in;
      old_idx_ff   <= old_idx_in;
      old_rec_ff   <= old_rec_in;
      cmd_ff       <= cmd_in;
      len_ff       <= len_in;
      now_ff       <= now_in;
      marker_ff    <= marker_in;
      tflags_ff    <= tflags_in;
      res_rec_ff   <= res_rec_in;
   end

   // A result is only offered to the output register while it can take it
   // or the sequencer waits in the emit state.
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (res.valid && !res_ready) |=> res.valid && $stable(res.rec))
      else $error("result changed while waiting for the output register");

   // An added NAL without marker leaves its slot valid.
   a_slot_taken: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && cmd_ff == nalau_pkg::CMD_ADD && !marker_ff)
      |=> valid_ff[$past(slot_idx)])
      else $error("slot not marked valid after an add");

   // A completed unit is freed when its result is produced.
   a_slot_freed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && cmd_ff == nalau_pkg::CMD_ADD && marker_ff)
      |=> !valid_ff[$past(slot_idx)])
      else $error("completed unit still valid");

   // The table grows by at most one unit per item.
   a_grow_one: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> $countones(valid_ff) <= $countones($past(valid_ff)) + 1)
      else $error("more than one slot taken in one cycle");

endmodule

[sv/nal_access_unit_tracker_core.sv]
// Top level of the NAL access unit tracker: stream ports, max_age register,
// and the sequencer, slot memory and output register (uses nalau_pkg).
//
// Use: each input transfer carries one NAL descriptor (req_tuser = 0) or a
// flush command (req_tuser = 1); req_tlast is the RTP marker bit. NALs are
// grouped by RTP timestamp in a table of ENTRIES pending access units. A
// marker completes the unit and sends its descriptor on the rsp channel; a
// flush sends the unit with the smallest timestamp. csr_we writes max_age,
// the age in 90 kHz ticks past which pending units are dropped after a marker.
// Flow: an item is accepted in the idle state, then the slot memory is scanned
// one entry per cycle over its registered read port; a decide step updates an
// added NAL's slot, and for a marker or a flush that finds a unit an emit step
// hands a result to the output register. No item is accepted before the last is
// through; a short NAL is dropped on acceptance. The memory scan sets the rate.
// Reset clears the slot valid bits at once and loads max_age with 180000; no
// memory clearing pass is needed. When the receiver stalls, one result waits in
// the output register while the next item is processed; a second result waits
// in the sequencer, which then accepts nothing until the register frees up.
module nal_access_unit_tracker_core #(
   parameter int ENTRIES = nalau_pkg::DEF_ENTRIES,
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // lead_bytes, nal_length, rtp_time
   input  logic        req_tuser,   // command
   input  logic        req_tlast,   // marker_bit
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // au_time, nal_total, au_bytes
   output logic [2:0]  rsp_tuser,   // is_idr, has_sps, has_pps
   input  logic        csr_we,
   input  logic [30:0] csr_wdata    // max_age
);

   logic [30:0] max_age_ff;
   logic [30:0] max_age_in;

   logic                    ram_wr_en;
   logic [IW-1:0]           ram_wr_addr;
   nalau_pkg::slot_rec_type ram_wr_data;
   logic [IW-1:0]           ram_rd_addr;
   nalau_pkg::slot_rec_type ram_rd_data;
   nalau_pkg::result_type   res;
   logic                    res_ready;

   assign max_age_in = csr_we ? csr_wdata : max_age_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff <= nalau_pkg::MAX_AGE_RESET;
      end else begin
         max_age_ff <= max_age_in;
      end
   end

   nalau_ctrl #(
      .ENTRIES(ENTRIES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .max_age     (max_age_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .cmd         (req_tuser),
      .lead        (req_tdata[39:0]),
      .len         (req_tdata[55:40]),
      .now         (req_tdata[87:56]),
      .marker      (req_tlast),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .res         (res),
      .res_ready   (res_ready)
   );

   nalau_slot_ram #(
      .ENTRIES(ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   nalau_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .res        (res),
      .res_ready  (res_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
